/* sv/pbg_pkg.sv */
// ----------------------------------------------------------------------------
// pbg_pkg
// Shared types and constants for the page framebuffer glyph blitter.
// ----------------------------------------------------------------------------
package pbg_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_NARROW = 2'd1,
    OP_WIDE   = 2'd2,
    OP_READ   = 2'd3
  } pbg_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BOUNDS  = 2'd1,
    ST_UNKNOWN = 2'd2
  } pbg_status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_BLIT,
    S_READ,
    S_WAIT
  } pbg_state_t;

  // byte edit for one read-modify-write step
  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] val;
  } pbg_step_t;

  localparam logic [2:0] NARROW_COLS  = 3'd5;   // glyph columns; the next is the spacer
  localparam logic [4:0] NARROW_STEPS = 5'd12;  // 6 columns x 2 pages
  localparam logic [4:0] WIDE_STEPS   = 5'd16;  // one byte per pixel column
  localparam logic [3:0] WIDE_MSB     = 4'd15;
  localparam logic [7:0] GLYPH_MASK   = 8'h7F;  // rows 0..6 of a narrow column
  localparam logic [7:0] SPACER_MASK  = 8'hFF;

endpackage

/* sv/pbg_frame_ram.sv */
// ----------------------------------------------------------------------------
// pbg_frame_ram
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbg_frame_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/pbg_step_gen.sv */
// ----------------------------------------------------------------------------
// pbg_step_gen
// Address and byte edit for one step of a glyph blit.
// ----------------------------------------------------------------------------
module pbg_step_gen #(
  parameter int PIXEL_WIDTH = 128,
  parameter int ADDR_W      = 10
) (
  input  logic              wide,
  input  logic [3:0]        step,
  input  logic [7:0]        x_pos,
  input  logic [7:0]        y_pos,
  input  logic [3:0]        row_index,
  input  logic [34:0]       glyph_columns,
  input  logic [15:0]       wide_row_bits,
  output logic [ADDR_W-1:0] addr,
  output pbg_pkg::pbg_step_t edit
);
  import pbg_pkg::*;

  logic [2:0]  col_sel;
  logic        half;
  logic [6:0]  col_bits;
  logic [7:0]  m8;
  logic [7:0]  v8;
  logic [15:0] m16;
  logic [15:0] v16;
  logic [8:0]  row_y;
  logic [7:0]  col;
  logic [5:0]  page;
  logic [13:0] lin;

  always_comb begin
    // narrow: step = 2*column + page half
    col_sel = step[3:1];
    half    = step[0];
    case (col_sel)
      3'd0:    col_bits = glyph_columns[6:0];
      3'd1:    col_bits = glyph_columns[13:7];
      3'd2:    col_bits = glyph_columns[20:14];
      3'd3:    col_bits = glyph_columns[27:21];
      3'd4:    col_bits = glyph_columns[34:28];
      default: col_bits = '0;
    endcase
    if (col_sel == NARROW_COLS) begin
      m8 = SPACER_MASK;
      v8 = '0;
    end else begin
      m8 = GLYPH_MASK;
      v8 = {1'b0, col_bits};
    end
    // straddles two pages unless y is page aligned
    m16   = {8'h00, m8} << y_pos[2:0];
    v16   = {8'h00, v8} << y_pos[2:0];
    row_y = {1'b0, y_pos} + {5'b0, row_index};

    if (wide) begin
      col       = x_pos + {4'b0, step};
      page      = row_y[8:3];
      edit.mask = 8'h01 << row_y[2:0];
      edit.val  = wide_row_bits[WIDE_MSB - step] ? edit.mask : 8'h00;
    end else begin
      col       = x_pos + {5'b0, col_sel};
      page      = {1'b0, y_pos[7:3]} + {5'b0, half};
      edit.mask = half ? m16[15:8] : m16[7:0];
      edit.val  = half ? v16[15:8] : v16[7:0];
    end

    lin  = {6'b0, col} + 14'(page * PIXEL_WIDTH);
    addr = lin[ADDR_W-1:0];
  end

endmodule

/* sv/page_framebuffer_glyph_blitter_unit.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_blitter_unit
// Monochrome page-layout framebuffer: clear, narrow glyph, wide glyph row
// and byte read, each returning one status word.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------
//  item    | item_valid / item_ready     | opcode, x_pos, y_pos, glyph_columns,
//          |                             | wide_row_bits, row_index,
//          |                             | glyph_known, read_page, read_column
//  result  | result_valid / result_ready | status, read_data
//
// One word at a time. Reads and write-backs of the bytes a blit touches
// overlap on the two frame store ports. After reset a clearing pass over
// the whole frame store runs before item_ready.
// A stalled result holds the finished word; the next word is still taken.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_blitter_unit #(
  parameter int PIXEL_WIDTH  = 128,
  parameter int PIXEL_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  x_pos,
  input  logic [7:0]  y_pos,
  input  logic [34:0] glyph_columns,
  input  logic [15:0] wide_row_bits,
  input  logic [3:0]  row_index,
  input  logic        glyph_known,
  input  logic [2:0]  read_page,
  input  logic [6:0]  read_column,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [7:0]  read_data
);
  import pbg_pkg::*;

  localparam int PAGE_COUNT = (PIXEL_HEIGHT + 7) / 8;
  localparam int STORE_SIZE = PIXEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  localparam logic [8:0]        NARROW_X_MAX = 9'(PIXEL_WIDTH - 6);
  localparam logic [8:0]        NARROW_Y_MAX = 9'(PIXEL_HEIGHT - 8);
  localparam logic [8:0]        WIDE_X_MAX   = 9'(PIXEL_WIDTH - 16);
  localparam logic [8:0]        WIDE_Y_MAX   = 9'(PIXEL_HEIGHT - 16);
  localparam logic [5:0]        READ_PAGES   = 6'(PAGE_COUNT);
  localparam logic [8:0]        READ_COLS    = 9'(PIXEL_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STORE_SIZE - 1);

  pbg_state_t  state;
  pbg_state_t  state_next;
  logic        acc;
  logic        sweep_last;
  logic        blit_last;
  logic        out_free;

  // decode of the word on the item port
  pbg_status_t acc_status;
  logic        acc_draw;
  logic        acc_read;

  logic [ADDR_W-1:0] sweep_addr;
  logic [4:0]        step;
  logic [4:0]        last_step;
  logic              cur_wide;
  logic [7:0]        cur_x;
  logic [7:0]        cur_y;
  logic [3:0]        cur_row;
  logic [34:0]       cur_cols;
  logic [15:0]       cur_bits;
  pbg_status_t       res_status;
  logic [7:0]        res_data;

  // write-back stage
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr_q;
  pbg_step_t         wr_edit;

  logic [ADDR_W-1:0] gen_addr;
  pbg_step_t         gen_edit;
  logic [13:0]       read_lin;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  pbg_step_gen #(
    .PIXEL_WIDTH (PIXEL_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_step (
    .wide          (cur_wide),
    .step          (step[3:0]),
    .x_pos         (cur_x),
    .y_pos         (cur_y),
    .row_index     (cur_row),
    .glyph_columns (cur_cols),
    .wide_row_bits (cur_bits),
    .addr          (gen_addr),
    .edit          (gen_edit)
  );

  pbg_frame_ram #(
    .DEPTH  (STORE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign acc        = item_valid && item_ready;
  assign sweep_last = (sweep_addr == LAST_ADDR);
  assign blit_last  = (step == last_step);
  assign out_free   = !result_valid || result_ready;
  assign read_lin   = {7'b0, read_column} + 14'(read_page * PIXEL_WIDTH);

  always_comb begin
    acc_status = ST_OK;
    acc_draw   = 1'b0;
    acc_read   = 1'b0;
    unique case (pbg_op_t'(opcode))
      OP_CLEAR: begin
        acc_status = ST_OK;
      end
      OP_NARROW: begin
        if ({1'b0, x_pos} > NARROW_X_MAX || {1'b0, y_pos} > NARROW_Y_MAX) begin
          acc_status = ST_BOUNDS;
        end else begin
          acc_draw   = 1'b1;
          acc_status = glyph_known ? ST_OK : ST_UNKNOWN;
        end
      end
      OP_WIDE: begin
        if ({1'b0, x_pos} > WIDE_X_MAX || {1'b0, y_pos} > WIDE_Y_MAX) begin
          acc_status = ST_BOUNDS;
        end else if (!glyph_known) begin
          acc_status = ST_UNKNOWN;
        end else begin
          acc_draw = 1'b1;
        end
      end
      OP_READ: begin
        if ({3'b0, read_page} >= READ_PAGES || {2'b0, read_column} >= READ_COLS) begin
          acc_status = ST_BOUNDS;
        end else begin
          acc_read = 1'b1;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (pbg_op_t'(opcode) == OP_CLEAR) begin
            state_next = S_CLEAR;
          end else if (acc_draw) begin
            state_next = S_BLIT;
          end else if (acc_read) begin
            state_next = S_READ;
          end else begin
            state_next = S_WAIT;
          end
        end
      end
      S_CLEAR: begin
        if (sweep_last) state_next = S_WAIT;
      end
      S_BLIT: begin
        if (blit_last) state_next = S_WAIT;
      end
      S_READ: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    item_ready = (state == S_IDLE);
    rd_en      = 1'b0;
    rd_addr    = read_lin[ADDR_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = sweep_addr;
    wr_data    = 8'h00;
    unique case (state)
      S_INIT, S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        rd_en = acc && acc_read;
      end
      S_BLIT: begin
        // read step n while step n-1 is written back; entries differ
        rd_en   = !blit_last && (gen_edit.mask != 8'h00);
        rd_addr = gen_addr;
        wr_en   = wr_pend;
        wr_addr = wr_addr_q;
        wr_data = (rd_data & ~wr_edit.mask) | (wr_edit.val & wr_edit.mask);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      sweep_addr   <= '0;
      step         <= '0;
      wr_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_INIT || state == S_CLEAR) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end

      if (state == S_BLIT) begin
        step    <= step + 1'b1;
        wr_pend <= !blit_last && (gen_edit.mask != 8'h00);
      end else begin
        step    <= '0;
        wr_pend <= 1'b0;
      end

      if (state == S_WAIT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      cur_wide   <= (pbg_op_t'(opcode) == OP_WIDE);
      cur_x      <= x_pos;
      cur_y      <= y_pos;
      cur_row    <= row_index;
      cur_cols   <= glyph_columns;
      cur_bits   <= wide_row_bits;
      last_step  <= (pbg_op_t'(opcode) == OP_WIDE) ? WIDE_STEPS : NARROW_STEPS;
      res_status <= acc_status;
      res_data   <= 8'h00;
    end
    if (state == S_BLIT) begin
      wr_addr_q <= gen_addr;
      wr_edit   <= gen_edit;
    end
    if (state == S_READ) begin
      res_data <= rd_data;
    end
    if (state == S_WAIT && out_free) begin
      status    <= res_status;
      read_data <= res_data;
    end
  end

endmodule

/* sv/pbg_checker.sv */
// ----------------------------------------------------------------------------
// pbg_checker
// Port-level checks for the glyph blitter, bound to the top level.
// ----------------------------------------------------------------------------
module pbg_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  status,
  input logic [7:0]  read_data
);
  import pbg_pkg::*;

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status) && $stable(read_data))
    else $error("result word changed while stalled");

  // one word in flight: busy straight after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous word still in flight");

  // a result never appears in the cycle after a word is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(item_valid && item_ready))
    else $error("result appeared too early after accept");

  // stored data comes back only with a good status
  a_data_needs_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && read_data != 8'h00 |-> status == ST_OK)
    else $error("non-zero read data with error status");

  // clearing pass after reset: nothing taken, nothing returned
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_ready)
    else $error("activity straight after reset");

endmodule

bind page_framebuffer_glyph_blitter_unit pbg_checker u_pbg_checker (.*);
